[hw/rtl/atce_pkg.sv]
// ----------------------------------------------------------------------------
// atce_pkg
// Shared constants for the text console engine: geometry defaults, character
// codes, SGR codes, register indexes and stream field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atce_pkg;

    localparam int COLUMNS_DEFAULT    = 80;
    localparam int ROWS_DEFAULT       = 25;
    localparam int MAX_PARAMS_DEFAULT = 8;

    localparam int CELL_W   = 16;
    localparam int PARAM_W  = 14;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 2'd2;

    localparam logic [31:0] RESET_COLOR_MAP = 32'd4082229824;
    localparam logic [3:0]  RESET_FG = 4'd15;
    localparam logic [3:0]  RESET_BG = 4'd0;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_SAVE   = 8'h37;
    localparam logic [7:0] CH_REST   = 8'h38;
    localparam logic [7:0] CH_CSI    = 8'h5B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SGR    = 8'h6D;

    localparam logic [PARAM_W-1:0] SGR_FG_LO  = 14'd30;
    localparam logic [PARAM_W-1:0] SGR_FG_HI  = 14'd37;
    localparam logic [PARAM_W-1:0] SGR_FG_DEF = 14'd39;
    localparam logic [PARAM_W-1:0] SGR_BG_LO  = 14'd40;
    localparam logic [PARAM_W-1:0] SGR_BG_HI  = 14'd47;
    localparam logic [PARAM_W-1:0] SGR_BG_DEF = 14'd49;
    localparam logic [16:0] PARAM_SAT = 17'd9999;
    localparam logic [16:0] DEC_BASE  = 17'd10;

endpackage

`default_nettype wire

[hw/rtl/ansi_text_console_engine.sv]
// ----------------------------------------------------------------------------
// ansi_text_console_engine
// VT100-style text console over a cell store in block RAM.
//
// Input stream s_axis: tuser = operation (0 feed byte, 1 read cell),
// tdata = char_code and cell_address, tlast = last byte of a write burst.
// Output stream m_axis: one item per input item, carrying the addressed cell
// on reads (zero otherwise) and the cursor after the item; tlast is the
// cursor update flag (tlast of a feed item, 0 on reads).
// Configuration: cfg_wr_en/cfg_index/cfg_wdata, write only, while idle.
// Flow: an accepted item passes through ST_EXEC (and ST_READ for reads)
// to ST_DONE, which loads the result; the next item is taken only after
// that, back in ST_IDLE. ESC [ ... m steps ST_SGR once per parameter up to
// the current index; a line feed or a wrap past the last row scrolls
// through the RAM one cell a cycle in ST_SCROLL. The single RAM port pair
// sets this.
// Reset: a clearing pass writes every cell with a blank in the reset
// colors, with s_axis_tready low; config is taken.
// Stall: the result sits in an output register; the next item is accepted
// and processed, and waits at the end until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ansi_text_console_engine #(
    parameter int COLUMNS    = atce_pkg::COLUMNS_DEFAULT,
    parameter int ROWS       = atce_pkg::ROWS_DEFAULT,
    parameter int MAX_PARAMS = atce_pkg::MAX_PARAMS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] char_code, [18:8] cell_address, zero fill
    input  wire logic [atce_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_char, [11:8] read_foreground, [15:12] read_background,
    // [20:16] cursor_row_out, [27:21] cursor_col_out, [38:28] cursor_linear
    output logic [atce_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [atce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [atce_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW = $clog2(CELLS);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int PW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int PMW = atce_pkg::PARAM_W;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_EXEC, ST_READ, ST_SCROLL, ST_SGR, ST_DONE
    } state_t;
    typedef enum logic [1:0] {MODE_NORMAL, MODE_ESC, MODE_SQUARE} mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic pend_v_reg, pend_v_next, pend_blank_reg, pend_blank_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [PW-1:0] pidx_reg, pidx_next, sgr_cnt_reg, sgr_cnt_next;
    logic [PMW-1:0] params_reg [MAX_PARAMS];
    logic [PMW-1:0] params_next [MAX_PARAMS];
    logic [RW-1:0] row_reg, row_next, srow_reg, srow_next;
    logic [CW-1:0] col_reg, col_next, scol_reg, scol_next;
    logic [3:0] fg_reg, fg_next, bg_reg, bg_next;
    logic [31:0] map_reg;
    logic [3:0] dfg_reg, dbg_reg;
    logic in_op_reg, in_op_next, in_last_reg, in_last_next;
    logic [7:0] in_ch_reg, in_ch_next;
    logic [10:0] in_addr_reg, in_addr_next;
    logic [15:0] rdata_reg, rdata_next;
    logic m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [atce_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0] ram_wdata, ram_rdata;

    logic [AW-1:0] cur_lin;
    logic [31:0] lin32, row32, col32, addr32;
    logic [16:0] dig_val;
    logic [PMW-1:0] sgr_p, sgr_off;
    logic [15:0] blank_cell;

    assign cur_lin = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign lin32  = 32'(cur_lin);
    assign row32  = 32'(row_reg);
    assign col32  = 32'(col_reg);
    assign addr32 = 32'(in_addr_reg);
    assign dig_val = 17'(params_reg[pidx_reg]) * atce_pkg::DEC_BASE
                   + 17'(in_ch_reg - atce_pkg::CH_ZERO);
    assign sgr_p   = params_reg[sgr_cnt_reg];
    assign sgr_off = sgr_p - ((sgr_p <= atce_pkg::SGR_FG_HI) ? atce_pkg::SGR_FG_LO
                                                            : atce_pkg::SGR_BG_LO);
    assign blank_cell = {bg_reg, fg_reg, atce_pkg::CH_SPACE};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    atce_ram #(.WIDTH(atce_pkg::CELL_W), .DEPTH(CELLS)) u_cells (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        mode_next = mode_reg;
        cnt_next = cnt_reg;
        pend_v_next = 1'b0;
        pend_blank_next = pend_blank_reg;
        pend_addr_next = pend_addr_reg;
        pidx_next = pidx_reg;
        sgr_cnt_next = sgr_cnt_reg;
        params_next = params_reg;
        row_next = row_reg;
        col_next = col_reg;
        srow_next = srow_reg;
        scol_next = scol_reg;
        fg_next = fg_reg;
        bg_next = bg_reg;
        in_op_next = in_op_reg;
        in_last_next = in_last_reg;
        in_ch_next = in_ch_reg;
        in_addr_next = in_addr_reg;
        rdata_next = rdata_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_last_next = m_last_reg;
        m_data_next = m_data_reg;
        ram_we = 1'b0;
        ram_waddr = cur_lin;
        ram_wdata = blank_cell;
        ram_raddr = '0;

        // finish the copy or blank issued by the scroll sweep last cycle
        if (pend_v_reg) begin
            ram_we = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_blank_reg ? blank_cell : ram_rdata;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = {atce_pkg::RESET_BG, atce_pkg::RESET_FG, atce_pkg::CH_SPACE};
                if (cnt_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    in_op_next = s_axis_tuser;
                    in_last_next = s_axis_tlast;
                    in_ch_next = s_axis_tdata[7:0];
                    in_addr_next = s_axis_tdata[18:8];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                rdata_next = '0;
                state_next = ST_DONE;
                if (in_op_reg) begin
                    ram_raddr = addr32[AW-1:0];
                    state_next = ST_READ;
                end else begin
                    unique case (mode_reg)
                        MODE_ESC: begin
                            mode_next = MODE_NORMAL;
                            priority if (in_ch_reg == atce_pkg::CH_SAVE) begin
                                srow_next = row_reg;
                                scol_next = col_reg;
                            end else if (in_ch_reg == atce_pkg::CH_REST) begin
                                row_next = srow_reg;
                                col_next = scol_reg;
                            end else if (in_ch_reg == atce_pkg::CH_CSI) begin
                                for (int i = 0; i < MAX_PARAMS; i++) begin
                                    params_next[i] = '0;
                                end
                                pidx_next = '0;
                                mode_next = MODE_SQUARE;
                            end else begin
                                // drop any other byte
                            end
                        end
                        MODE_SQUARE: begin
                            priority if (in_ch_reg >= atce_pkg::CH_ZERO &&
                                         in_ch_reg <= atce_pkg::CH_NINE) begin
                                params_next[pidx_reg] = (dig_val > atce_pkg::PARAM_SAT)
                                    ? PMW'(atce_pkg::PARAM_SAT) : PMW'(dig_val);
                            end else if (in_ch_reg == atce_pkg::CH_SEMI) begin
                                if (pidx_reg != PW'(MAX_PARAMS - 1)) begin
                                    pidx_next = pidx_reg + PW'(1);
                                end
                            end else begin
                                mode_next = MODE_NORMAL;
                                if (in_ch_reg == atce_pkg::CH_SGR) begin
                                    sgr_cnt_next = '0;
                                    state_next = ST_SGR;
                                end
                            end
                        end
                        default: begin
                            priority if (in_ch_reg == atce_pkg::CH_ESC) begin
                                mode_next = MODE_ESC;
                            end else if (in_ch_reg == atce_pkg::CH_DEL ||
                                         in_ch_reg == atce_pkg::CH_BS) begin
                                if (cur_lin != '0) begin
                                    if (col_reg != '0) begin
                                        col_next = col_reg - CW'(1);
                                    end else begin
                                        row_next = row_reg - RW'(1);
                                        col_next = CW'(COLUMNS - 1);
                                    end
                                    if (in_ch_reg == atce_pkg::CH_DEL) begin
                                        ram_we = 1'b1;
                                        ram_waddr = cur_lin - AW'(1);
                                    end
                                end
                            end else if (in_ch_reg == atce_pkg::CH_CR) begin
                                col_next = '0;
                            end else if (in_ch_reg == atce_pkg::CH_LF ||
                                         (in_ch_reg >= atce_pkg::CH_SPACE &&
                                          in_ch_reg <= atce_pkg::CH_TILDE)) begin
                                if (in_ch_reg != atce_pkg::CH_LF) begin
                                    ram_we = 1'b1;
                                    ram_wdata = {bg_reg, fg_reg, in_ch_reg};
                                end
                                if (in_ch_reg == atce_pkg::CH_LF ||
                                    col_reg == CW'(COLUMNS - 1)) begin
                                    col_next = '0;
                                    if (row_reg == RW'(ROWS - 1)) begin
                                        cnt_next = '0;
                                        state_next = ST_SCROLL;
                                    end else begin
                                        row_next = row_reg + RW'(1);
                                    end
                                end else begin
                                    col_next = col_reg + CW'(1);
                                end
                            end else begin
                                // ignore other control and high bytes
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (addr32 < 32'(CELLS)) begin
                    rdata_next = ram_rdata;
                end
                state_next = ST_DONE;
            end
            ST_SCROLL: begin
                // read one row ahead, write back next cycle; blank the last row
                pend_v_next = 1'b1;
                pend_addr_next = cnt_reg;
                pend_blank_next = (cnt_reg >= AW'(CELLS - COLUMNS));
                ram_raddr = cnt_reg + AW'(COLUMNS);
                if (cnt_reg == AW'(CELLS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_SGR: begin
                priority if (sgr_p >= atce_pkg::SGR_FG_LO && sgr_p <= atce_pkg::SGR_FG_HI) begin
                    fg_next = map_reg[{sgr_off[2:0], 2'b00} +: 4];
                end else if (sgr_p >= atce_pkg::SGR_BG_LO &&
                             sgr_p <= atce_pkg::SGR_BG_HI) begin
                    bg_next = map_reg[{sgr_off[2:0], 2'b00} +: 4];
                end else if (sgr_p == atce_pkg::SGR_FG_DEF) begin
                    fg_next = dfg_reg;
                end else if (sgr_p == atce_pkg::SGR_BG_DEF) begin
                    bg_next = dbg_reg;
                end else begin
                    // skip codes without a color meaning
                end
                if (sgr_cnt_reg == pidx_reg) begin
                    state_next = ST_DONE;
                end else begin
                    sgr_cnt_next = sgr_cnt_reg + PW'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_last_next = !in_op_reg && in_last_reg;
                    m_data_next = {1'b0, lin32[10:0], col32[6:0], row32[4:0], rdata_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            mode_reg <= MODE_NORMAL;
            cnt_reg <= '0;
            pend_v_reg <= 1'b0;
            pidx_reg <= '0;
            sgr_cnt_reg <= '0;
            for (int i = 0; i < MAX_PARAMS; i++) begin
                params_reg[i] <= '0;
            end
            row_reg <= '0;
            col_reg <= '0;
            srow_reg <= '0;
            scol_reg <= '0;
            fg_reg <= atce_pkg::RESET_FG;
            bg_reg <= atce_pkg::RESET_BG;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            cnt_reg <= cnt_next;
            pend_v_reg <= pend_v_next;
            pidx_reg <= pidx_next;
            sgr_cnt_reg <= sgr_cnt_next;
            params_reg <= params_next;
            row_reg <= row_next;
            col_reg <= col_next;
            srow_reg <= srow_next;
            scol_reg <= scol_next;
            fg_reg <= fg_next;
            bg_reg <= bg_next;
            m_valid_reg <= m_valid_next;
        end
        pend_blank_reg <= pend_blank_next;
        pend_addr_reg <= pend_addr_next;
        in_op_reg <= in_op_next;
        in_last_reg <= in_last_next;
        in_ch_reg <= in_ch_next;
        in_addr_reg <= in_addr_next;
        rdata_reg <= rdata_next;
        m_last_reg <= m_last_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg <= atce_pkg::RESET_COLOR_MAP;
            dfg_reg <= atce_pkg::RESET_FG;
            dbg_reg <= atce_pkg::RESET_BG;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                atce_pkg::CFG_COLOR_MAP:  map_reg <= cfg_wdata;
                atce_pkg::CFG_DEFAULT_FG: dfg_reg <= cfg_wdata[3:0];
                atce_pkg::CFG_DEFAULT_BG: dbg_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/atce_ram.sv]
// ----------------------------------------------------------------------------
// atce_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
